FILE: rtl/shse_pkg.sv
// Package: payload types, register map and codeword builder for the SECDED stream encoder.
`default_nettype none
package shse_pkg;

	localparam int MAX_DATA  = 57;
	localparam int CODE_W    = 64;
	localparam int CHECK_N   = 6;
	localparam int CNT_W     = 6;
	localparam int LEN_W     = 7;
	localparam int ADDR_W    = 3;

	localparam logic REQ_DATA  = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	localparam logic REG_DATA_LEN = 1'b0;

	localparam logic [CNT_W-1:0] DATA_LEN_RESET = 6'd4;

	typedef struct packed {
		logic req_type;
		logic data_bit;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_word;
		logic [LEN_W-1:0]  code_len;
	} code_t;

	// Data occupies all non-power-of-two positions; bits beyond k are zero, so the
	// check bits past the real code length come out zero as well.
	function automatic code_t shse_encode(input logic [MAX_DATA-1:0] data,
	                                      input logic [CNT_W-1:0] k);
		logic [CODE_W-1:0] cw;
		logic [LEN_W-1:0]  len;
		logic [2:0]        r;
		logic              p;
		logic              all_par;
		logic [CNT_W-1:0]  last;
		code_t             res;
		int                j;
		cw = '0;
		j = 0;
		for (int pos = 1; pos < CODE_W; pos++) begin
			if ((pos & (pos - 1)) != 0) begin
				cw[pos-1] = data[j];
				j++;
			end
		end
		for (int d = 0; d < CHECK_N; d++) begin
			p = 1'b0;
			for (int pos = 1; pos < CODE_W; pos++) begin
				if (((pos >> d) & 1) != 0)
					p = p ^ cw[pos-1];
			end
			cw[(1 << d) - 1] = p;
		end
		if (k <= 6'd1)
			r = 3'd2;
		else if (k <= 6'd4)
			r = 3'd3;
		else if (k <= 6'd11)
			r = 3'd4;
		else if (k <= 6'd26)
			r = 3'd5;
		else
			r = 3'd6;
		len = {1'b0, k} + {4'b0, r} + 7'd1;
		last = len[CNT_W-1:0] - 6'd1;
		all_par = ^cw;
		cw = cw | ({{(CODE_W-1){1'b0}}, all_par} << last);
		res.code_word = cw;
		res.code_len = len;
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/secded_hamming_stream_encoder.sv
// Top level: serial bit collector and extended Hamming SECDED encoder.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one data bit or an
//   end-of-stream marker per transaction. Data bits fill a word; once it holds
//   data_len bits (register 0, range 1..57, reset 4) the word is encoded.
//   End of stream encodes a partial word; with nothing collected it is dropped.
//   code channel (code_valid/code_ready/code) carries the codeword, position 1
//   in bit 0, overall parity at bit code_len-1, and its length.
// Timing:
//   one transaction per cycle on the item side while item_ready is high. A
//   word-closing item is held in the capture stage, then the output register. The
//   encode stage is fixed parity logic: one item a cycle while not stalled.
// Stall:
//   while code_ready is low one more finished word waits in the capture stage;
//   item_ready drops only when that stage is full and the output is stalled.
// Reset:
//   arst_n clears the partial word, both stages and restores data_len to 4.
`default_nettype none
module secded_hamming_stream_encoder import shse_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire item_t             item,
	output logic                   code_valid,
	input  wire logic              code_ready,
	output code_t                  code
);

	logic [CNT_W-1:0]    data_len_q;
	logic [MAX_DATA-1:0] word_q;
	logic [CNT_W-1:0]    count_q;
	logic [MAX_DATA-1:0] word_s1;
	logic [CNT_W-1:0]    k_s1;
	logic                valid_s1;
	code_t               code_q;
	logic                code_valid_q;

	logic                advance;
	logic                accept;
	logic [CNT_W-1:0]    eff_len;
	logic                has_room;
	logic [MAX_DATA-1:0] word_next;
	logic [CNT_W-1:0]    count_next;
	logic                emit;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DATA_LEN) ? {26'b0, data_len_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_len_q <= DATA_LEN_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_DATA_LEN)) begin
			data_len_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		if (data_len_q == '0)
			eff_len = 6'd1;
		else if (data_len_q > 6'(MAX_DATA))
			eff_len = 6'(MAX_DATA);
		else
			eff_len = data_len_q;
	end

	assign advance    = !code_valid_q || code_ready;
	assign item_ready = !valid_s1 || advance;
	assign accept     = item_valid && item_ready;

	always_comb begin
		has_room = count_q < 6'(MAX_DATA);
		word_next = word_q;
		count_next = count_q;
		if (item.req_type == REQ_FLUSH) begin
			emit = count_q != '0;
		end else begin
			if (has_room) begin
				word_next = word_q | ({{(MAX_DATA-1){1'b0}}, item.data_bit} << count_q);
				count_next = count_q + 6'd1;
			end
			emit = count_next >= eff_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (emit) begin
				word_q <= '0;
				count_q <= '0;
			end else begin
				word_q <= word_next;
				count_q <= count_next;
			end
		end
	end

	// Capture stage: hold a finished word until the encode stage can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && emit) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			word_s1 <= word_next;
			k_s1 <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (advance) begin
			code_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			code_q <= shse_encode(word_s1, k_s1);
		end
	end

	assign code_valid = code_valid_q;
	assign code       = code_q;

endmodule
`default_nettype wire

FILE: rtl/shse_checker.sv
// Checker: port-level properties of the SECDED stream encoder, bound to the top level.
`default_nettype none
module shse_port_checker import shse_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  code_valid,
	input wire logic  code_ready,
	input wire code_t code
);

	a_code_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_ready |=> code_valid && $stable(code))
		else $error("stalled code transaction changed");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> (code.code_len >= 7'd4) && (code.code_len <= 7'd64))
		else $error("code length out of range");

	a_even_parity: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> (^code.code_word) == 1'b0)
		else $error("codeword overall parity is odd");

	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && (code.code_len != 7'd64) |-> (code.code_word >> code.code_len) == '0)
		else $error("codeword has bits beyond its length");

endmodule

bind secded_hamming_stream_encoder shse_port_checker u_shse_port_checker (.*);
`default_nettype wire
